// ===== hdl/nprc_pkg.sv =====
// package for the nested pixel to ring coordinate unit
// field widths, face corner tables and default order limit; no dependencies

package nprc_pkg;

	localparam int unsigned ORDER_W       = 4;
	localparam int unsigned PIX_W         = 30;
	localparam int unsigned FACE_W        = 4;
	localparam int unsigned RING_W        = 15;
	localparam int unsigned POS_W         = 16;
	localparam int unsigned CNT_W         = 14;
	localparam int unsigned ZS_W          = 29;
	localparam int unsigned NUM_FACES     = 12;
	localparam int unsigned DEF_MAX_ORDER = 13;

	// ring row of each base face, in units of side
	function automatic logic [2:0] face_row(input logic [FACE_W-1:0] face);
		logic [2:0] r;
		case (face)
			4'd0, 4'd1, 4'd2, 4'd3: r = 3'd2;
			4'd4, 4'd5, 4'd6, 4'd7: r = 3'd3;
			default:                r = 3'd4;
		endcase
		return r;
	endfunction

	// phi column of each base face
	function automatic logic [2:0] face_col(input logic [FACE_W-1:0] face);
		logic [2:0] c;
		case (face)
			4'd0, 4'd8:  c = 3'd1;
			4'd1, 4'd9:  c = 3'd3;
			4'd2, 4'd10: c = 3'd5;
			4'd3, 4'd11: c = 3'd7;
			4'd4:        c = 3'd0;
			4'd5:        c = 3'd2;
			4'd6:        c = 3'd4;
			default:     c = 3'd6;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/nested_pixel_to_ring_coords_unit.sv =====
// channel  | signals                         | moves
// in       | in_valid, in_ready, pixel_index | one nested pixel index per item
// out      | out_valid, out_ready, fields    | one ring coordinate result per item
// cfg      | cfg_we, cfg_wdata               | resolution order, no wait
//
// four register stages: de-interleave and range check, ring and region,
// the two small multiplies, then z and phi wrap into the output register.
// one item per cycle while the output is not stalled; out_valid is the stage 4 valid.
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and no item is lost or repeated. arst_n clears valids and order.
// depends on nprc_pkg

module nested_pixel_to_ring_coords_unit
	import nprc_pkg::*;
#(
	parameter int unsigned MAX_ORDER = DEF_MAX_ORDER
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ORDER_W-1:0]  cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [FACE_W-1:0]   face_number,
	output logic [RING_W-1:0]   ring_index,
	output logic [POS_W-1:0]    ring_position,
	output logic [CNT_W-1:0]    ring_count,
	output logic                half_shift,
	output logic signed [ZS_W-1:0] z_scaled,
	output logic                range_error
);

	localparam int unsigned XY_W  = MAX_ORDER;
	localparam int unsigned NR_W  = MAX_ORDER + 1;
	localparam int unsigned JR_W  = MAX_ORDER + 3;
	localparam int unsigned NUM_W = NR_W + 5;
	localparam int unsigned SQ_W  = 2 * NR_W;
	localparam int unsigned Z_W   = 2 * MAX_ORDER + 3;

	logic [ORDER_W-1:0] order_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// each stage moves when empty or when the next one moves
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: face, range check, bit de-interleave
	logic [ORDER_W-1:0] ord_c;
	logic [PIX_W-1:0]   face_full, face_mask, inface;
	logic [XY_W-1:0]    ix_c, iy_c;

	always_comb begin
		ord_c     = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;
		face_full = pixel_index >> {ord_c, 1'b0};
		face_mask = (PIX_W'(1) << {ord_c, 1'b0}) - PIX_W'(1);
		inface    = pixel_index & face_mask;
		for (int k = 0; k < XY_W; k++) begin
			ix_c[k] = inface[2*k];
			iy_c[k] = inface[2*k+1];
		end
	end

	logic [ORDER_W-1:0] ord_s1;
	logic [FACE_W-1:0]  face_s1;
	logic               err_s1;
	logic [XY_W-1:0]    ix_s1, iy_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ord_s1  <= ord_c;
			face_s1 <= face_full[FACE_W-1:0];
			err_s1  <= face_full >= PIX_W'(NUM_FACES);
			ix_s1   <= ix_c;
			iy_s1   <= iy_c;
		end
	end

	// stage 2: ring number and polar / equatorial region
	logic [JR_W-1:0] side_w, three_side, four_side, row_side, jr_c;
	logic [XY_W:0]   jrt_c;
	logic            north_c, south_c;
	logic [NR_W-1:0] nr_c;
	logic            kshift_c;
	logic signed [XY_W:0] jpt_c;

	always_comb begin
		side_w     = JR_W'(1) << ord_s1;
		three_side = (side_w << 1) + side_w;
		four_side  = side_w << 2;
		row_side   = JR_W'(face_row(face_s1)) << ord_s1;
		jrt_c      = {1'b0, ix_s1} + {1'b0, iy_s1};
		jr_c       = row_side - JR_W'(jrt_c) - JR_W'(1);
		north_c    = jr_c < side_w;
		south_c    = jr_c > three_side;
		if (north_c) begin
			nr_c = NR_W'(jr_c);
		end else if (south_c) begin
			nr_c = NR_W'(four_side - jr_c);
		end else begin
			nr_c = NR_W'(side_w);
		end
		// equatorial rings alternate their half-step offset
		kshift_c = !north_c && !south_c && (jr_c[0] ^ side_w[0]);
		jpt_c    = $signed({1'b0, ix_s1}) - $signed({1'b0, iy_s1});
	end

	logic [ORDER_W-1:0] ord_s2;
	logic [FACE_W-1:0]  face_s2;
	logic               err_s2, north_s2, south_s2, kshift_s2;
	logic [JR_W-1:0]    jr_s2;
	logic [NR_W-1:0]    nr_s2;
	logic signed [XY_W:0] jpt_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			ord_s2    <= ord_s1;
			face_s2   <= face_s1;
			err_s2    <= err_s1;
			north_s2  <= north_c;
			south_s2  <= south_c;
			kshift_s2 <= kshift_c;
			jr_s2     <= jr_c;
			nr_s2     <= nr_c;
			jpt_s2    <= jpt_c;
		end
	end

	// stage 3: nr squared and the phi numerator
	logic [NR_W+2:0] colnr_c;
	logic signed [NUM_W-1:0] num_c;

	always_comb begin
		colnr_c = (NR_W+3)'(face_col(face_s2)) * (NR_W+3)'(nr_s2);
		num_c   = NUM_W'($signed({1'b0, colnr_c})) + NUM_W'(jpt_s2)
			+ NUM_W'({1'b0, kshift_s2}) + NUM_W'(1);
	end

	logic [ORDER_W-1:0] ord_s3;
	logic [FACE_W-1:0]  face_s3;
	logic               err_s3, north_s3, south_s3, kshift_s3;
	logic [JR_W-1:0]    jr_s3;
	logic [NR_W-1:0]    nr_s3;
	logic [SQ_W-1:0]    nsq_s3;
	logic signed [NUM_W-1:0] num_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			ord_s3    <= ord_s2;
			face_s3   <= face_s2;
			err_s3    <= err_s2;
			north_s3  <= north_s2;
			south_s3  <= south_s2;
			kshift_s3 <= kshift_s2;
			jr_s3     <= jr_s2;
			nr_s3     <= nr_s2;
			nsq_s3    <= nr_s2 * nr_s2;
			num_s3    <= num_c;
		end
	end

	// stage 4: z and the halved, wrapped ring position
	logic [Z_W-1:0]          three_ss;
	logic [JR_W-1:0]         side2;
	logic signed [JR_W:0]    zd;
	logic signed [Z_W-1:0]   zd_ext, z_c;
	logic signed [NUM_W-1:0] num_adj, half, nl4, jp1, jp_c;

	always_comb begin
		three_ss = Z_W'(3) << {ord_s3, 1'b0};
		side2    = JR_W'(1) << (ord_s3 + ORDER_W'(1));
		zd       = $signed({1'b0, side2}) - $signed({1'b0, jr_s3});
		zd_ext   = Z_W'(zd);
		if (north_s3) begin
			z_c = three_ss - Z_W'(nsq_s3);
		end else if (south_s3) begin
			z_c = Z_W'(nsq_s3) - three_ss;
		end else begin
			z_c = zd_ext << (ord_s3 + ORDER_W'(1));
		end
		// halve toward zero
		num_adj = num_s3 + NUM_W'({1'b0, num_s3[NUM_W-1]});
		half    = num_adj >>> 1;
		nl4     = NUM_W'(1) << (ord_s3 + ORDER_W'(2));
		jp1     = (half > nl4) ? (half - nl4) : half;
		jp_c    = (jp1[NUM_W-1] || jp1 == '0) ? (jp1 + nl4) : jp1;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			range_error <= err_s3;
			if (err_s3) begin
				face_number   <= '0;
				ring_index    <= '0;
				ring_position <= '0;
				ring_count    <= '0;
				half_shift    <= 1'b0;
				z_scaled      <= '0;
			end else begin
				face_number   <= face_s3;
				ring_index    <= RING_W'(jr_s3);
				ring_position <= POS_W'(jp_c);
				ring_count    <= CNT_W'(nr_s3);
				half_shift    <= !kshift_s3;
				z_scaled      <= ZS_W'(z_c);
			end
		end
	end

	assign out_valid = v_s4;

endmodule

// ===== dv/nested_pixel_to_ring_coords_unit_tb.sv =====
// testbench for nested_pixel_to_ring_coords_unit: directed, random and back-pressure items
// checked against an in-bench ring coordinate predictor; depends on nprc_pkg and the unit

module nested_pixel_to_ring_coords_unit_tb;
	import nprc_pkg::*;

	localparam int unsigned SAT_ORDER       = DEF_MAX_ORDER;
	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned TAIL_CYCLES     = 8;
	localparam int unsigned ITEMS_PER_ORDER = 90;
	localparam int unsigned LONG_HOLD       = 300;
	localparam int unsigned BURST_ITEMS     = 60;

	typedef struct packed {
		logic [FACE_W-1:0]      face;
		logic [RING_W-1:0]      ring;
		logic [POS_W-1:0]       pos;
		logic [CNT_W-1:0]       cnt;
		logic                   half;
		logic signed [ZS_W-1:0] z;
		logic                   err;
	} ring_coords_t;

	typedef struct {
		logic [PIX_W-1:0]   pix;
		logic [ORDER_W-1:0] order;
		ring_coords_t       coords;
	} pending_coords_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [ORDER_W-1:0]     cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [PIX_W-1:0]       pixel_index;
	logic                   out_valid;
	logic                   out_ready;
	logic [FACE_W-1:0]      face_number;
	logic [RING_W-1:0]      ring_index;
	logic [POS_W-1:0]       ring_position;
	logic [CNT_W-1:0]       ring_count;
	logic                   half_shift;
	logic signed [ZS_W-1:0] z_scaled;
	logic                   range_error;

	pending_coords_t    expected_coords_q[$];
	logic [ORDER_W-1:0] cur_order = '0;
	bit                 src_gaps = 1'b0;
	bit                 sink_stalls = 1'b0;
	int unsigned        sink_hold = 0;
	int unsigned        failures = 0;
	int unsigned        cycle_count = 0;

	nested_pixel_to_ring_coords_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_index   (pixel_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.face_number   (face_number),
		.ring_index    (ring_index),
		.ring_position (ring_position),
		.ring_count    (ring_count),
		.half_shift    (half_shift),
		.z_scaled      (z_scaled),
		.range_error   (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ring coordinates of one nested pixel at the given order setting
	function automatic ring_coords_t ring_coords_of(input logic [ORDER_W-1:0] order_reg,
			input logic [PIX_W-1:0] pix);
		ring_coords_t r;
		longint ord, p, face_pix, side, nl4, face, inface;
		longint ix, iy, jr, nr, ks, num, jp, z, row, col;
		r = '0;
		ord = (order_reg > SAT_ORDER) ? SAT_ORDER : order_reg;
		p = pix;
		face_pix = longint'(1) << (2 * ord);
		if (p >= 12 * face_pix) begin
			r.err = 1'b1;
			return r;
		end
		side = longint'(1) << ord;
		nl4 = 4 * side;
		face = p >> (2 * ord);
		inface = p & (face_pix - 1);
		ix = 0;
		iy = 0;
		for (int k = 0; k < SAT_ORDER; k++) begin
			ix |= ((inface >> (2 * k)) & 1) << k;
			iy |= ((inface >> (2 * k + 1)) & 1) << k;
		end
		// faces come in rows of four; the middle row starts at column zero
		row = 2 + face / 4;
		col = 2 * (face % 4) + ((face / 4 == 1) ? 0 : 1);
		jr = row * side - (ix + iy) - 1;
		nr = side;
		z = (2 * side - jr) * 2 * side;
		ks = (jr - side) & 1;
		if (jr < side) begin
			nr = jr;
			z = 3 * side * side - nr * nr;
			ks = 0;
		end else if (jr > 3 * side) begin
			nr = nl4 - jr;
			z = nr * nr - 3 * side * side;
			ks = 0;
		end
		num = col * nr + (ix - iy) + 1 + ks;
		// halve toward zero, then wrap once into the ring
		jp = (num >= 0) ? num / 2 : -((-num) / 2);
		if (jp > nl4)
			jp -= nl4;
		if (jp < 1)
			jp += nl4;
		r.face = FACE_W'(face);
		r.ring = RING_W'(jr);
		r.pos  = POS_W'(jp);
		r.cnt  = CNT_W'(nr);
		r.half = ~ks[0];
		r.z    = ZS_W'(z);
		return r;
	endfunction

	function automatic string coords_text(input ring_coords_t c);
		return $sformatf("face %0d ring %0d pos %0d cnt %0d half %0b z %0d err %0b",
			c.face, c.ring, c.pos, c.cnt, c.half, $signed(c.z), c.err);
	endfunction

	// mostly in range for the current order, some out of range, some anywhere
	function automatic logic [PIX_W-1:0] random_pixel();
		longint unsigned ord, total;
		int unsigned pick;
		ord = (cur_order > SAT_ORDER) ? SAT_ORDER : cur_order;
		total = 12 * (longint'(1) << (2 * ord));
		pick = $urandom_range(99, 0);
		if (pick < 80)
			return PIX_W'($urandom_range(int'(total - 1), 0));
		if (pick < 90)
			return PIX_W'($urandom_range(2 ** PIX_W - 1, int'(total)));
		return PIX_W'($urandom());
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int unsigned gap;
		pending_coords_t item;
		gap = src_gaps ? $urandom_range(4, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_index <= pix;
		do @(posedge clk); while (!in_ready);
		item.pix    = pix;
		item.order  = cur_order;
		item.coords = ring_coords_of(cur_order, pix);
		expected_coords_q = {expected_coords_q, item};
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_coords_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] ord);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= ord;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_order = ord;
	endtask

	task automatic test_directed();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		// one pixel per base face at the coarsest grid
		write_order(4'd0);
		for (int f = 0; f < NUM_FACES; f++)
			send_pixel(PIX_W'(f));
		send_pixel(PIX_W'(12));
		send_pixel('1);
		write_order(4'd2);
		send_pixel(PIX_W'(15));  // north polar cap
		send_pixel(PIX_W'(128)); // south polar cap
		send_pixel(PIX_W'(80));  // equatorial belt
		send_pixel(PIX_W'(74));  // phi index wraps up from below one
		send_pixel(PIX_W'(53));  // ring on the cap boundary, eastmost face
		send_pixel(PIX_W'(192)); // first index past the end
		write_order(4'd13);
		send_pixel('0);
		send_pixel(PIX_W'(805306367));
		send_pixel(PIX_W'(805306368));
	endtask

	task automatic test_random_orders();
		int unsigned plan[$] = '{0, 1, 13, 15, 5, 14, 2, 9, 3, 12, 7, 4, 10, 6, 11, 8};
		foreach (plan[i]) begin
			write_order(ORDER_W'(plan[i]));
			src_gaps = ($urandom_range(3, 0) != 0);
			sink_stalls = ($urandom_range(3, 0) != 0);
			repeat (ITEMS_PER_ORDER) send_pixel(random_pixel());
		end
	endtask

	task automatic test_backpressure();
		write_order(4'd7);
		src_gaps = 1'b0;
		sink_stalls = 1'b1;
		sink_hold = LONG_HOLD;
		repeat (BURST_ITEMS) send_pixel(random_pixel());
		// sender stands still until the pipeline has emptied
		wait_all_results();
		src_gaps = 1'b1;
		repeat (BURST_ITEMS) send_pixel(random_pixel());
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		pixel_index <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_orders();
		test_backpressure();
		wait_all_results();
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: random stall before each item when stalls are on, one long hold when asked
	initial begin : result_sink
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold != 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			stall = sink_stalls ? $urandom_range(4, 0) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		pending_coords_t want;
		ring_coords_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{face_number, ring_index, ring_position, ring_count, half_shift,
				z_scaled, range_error};
			if (expected_coords_q.size() == 0) begin
				if (failures < 10)
					$display("result with no item outstanding: %s", coords_text(got));
				failures++;
			end else begin
				want = expected_coords_q.pop_front();
				if (got !== want.coords) begin
					if (failures < 10) begin
						$display("pixel %0d order %0d expected %s", want.pix, want.order,
							coords_text(want.coords));
						$display("pixel %0d order %0d actual   %s", want.pix, want.order,
							coords_text(got));
					end
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
hdl/nprc_pkg.sv
hdl/nested_pixel_to_ring_coords_unit.sv
dv/nested_pixel_to_ring_coords_unit_tb.sv
